### rtl/kqs_pkg.sv
// Package for the Kuwahara quadrant select unit: widths, constants and types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package kqs_pkg;
   localparam int QuadSide = 4;
   localparam int QuadCap = QuadSide * QuadSide;
   localparam int NumQuads = 4;
   localparam int IdxW = $clog2(QuadCap);
   localparam int CntW = $clog2(QuadCap + 1);
   localparam int SumW = CntW + 8;
   localparam int SsdW = 16 + IdxW + 1;
   localparam int ProdW = SsdW + CntW;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusOverflow = 2'd1;
   localparam logic [1:0] StatusEmpty = 2'd2;

   typedef struct packed {
      logic [1:0] quadrant;
      logic [7:0] pixel;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] mean_value;
      logic [1:0] chosen_quadrant;
      logic [1:0] status;
   } rsp_type;
endpackage
`default_nettype wire

### rtl/kqs_chan_if.sv
// Valid/ready channel interface carrying one payload of a given type.
// Depends on kqs_pkg for the payload types.
`default_nettype none
interface kqs_req_if;
   logic              valid;
   logic              ready;
   kqs_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface kqs_rsp_if;
   logic              valid;
   logic              ready;
   kqs_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/kuwahara_quadrant_select_unit.sv
// Top level of the Kuwahara quadrant select unit.
// Depends on kqs_pkg, the channel interfaces, kqs_queue and kqs_engine.
//
// Usage: requests carry one window pixel with its quadrant (0..3) and a last
// flag. Each pixel is stored and added to its quadrant's sum and count; a
// pixel for a full quadrant is dropped and flagged in the status.
// A request marked last yields exactly one response: the rounded mean of the
// quadrant with the lowest spread, its index and a status code.
// Requests enter a two-entry queue, so the sender can place two requests
// while the back end finishes a window and is held after that.
// Ordinary pixels are stored and summed as they arrive. A last request then,
// for each quadrant in turn, searches its mean step by step and walks its
// stored samples through the single memory read port to sum the squared
// deviations (both end at once for a quadrant with fewer than two samples)
// and compares; then it rounds the chosen mean by a step-by-step search
// and presents the response. No request is taken until the response is taken.
// When the receiver stalls, the response holds and the back end waits, and
// requests back up into the queue. Reset clears all sums and counts and the
// overflow and found flags; samples are kept, as only written ones are used.
`default_nettype none
module kuwahara_quadrant_select_unit (
   input wire logic clock,
   input wire logic reset,
   kqs_req_if.sink  req,
   kqs_rsp_if.source rsp
);
   kqs_req_if mid ();

   kqs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .up    (req),
      .down  (mid)
   );

   kqs_engine u_engine (
      .clock (clock),
      .reset (reset),
      .req   (mid),
      .rsp   (rsp)
   );
endmodule
`default_nettype wire

### rtl/kqs_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on kqs_pkg and the channel interfaces.
`default_nettype none
module kqs_queue (
   input  wire logic clock,
   input  wire logic reset,
   kqs_req_if.sink   up,
   kqs_req_if.source down
);
   kqs_pkg::req_type slot_ff [2];
   kqs_pkg::req_type slot_in [2];
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign up.ready = (count_ff != 2'd2);
   assign down.valid = (count_ff != 2'd0);
   assign down.data = slot_ff[0];
   assign push = up.valid && up.ready;
   assign pop = down.valid && down.ready;

   always_comb begin
      slot_in = slot_ff;
      count_in = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         count_in = count_in - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = up.data;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

### rtl/kqs_engine.sv
// Back end: stores samples, accumulates sums and counts, and on the last request
// walks the stored samples to find the least-spread quadrant. Depends on kqs_pkg.
`default_nettype none
module kqs_engine (
   input  wire logic clock,
   input  wire logic reset,
   kqs_req_if.sink   req,
   kqs_rsp_if.source rsp
);
   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_MEAN  = 6'b000010,
      ST_WALK  = 6'b000100,
      ST_CMP   = 6'b001000,
      ST_ROUND = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   localparam int AddrW = 2 + kqs_pkg::IdxW;

   state_type state_ff, state_in;
   logic [7:0] mem [kqs_pkg::NumQuads * kqs_pkg::QuadCap];
   logic [7:0] rd_ff;
   logic [kqs_pkg::SumW-1:0] sum_ff [kqs_pkg::NumQuads];
   logic [kqs_pkg::CntW-1:0] cnt_ff [kqs_pkg::NumQuads];
   logic ovf_ff;
   logic [1:0] q_ff;
   logic [kqs_pkg::CntW-1:0] idx_ff;
   logic rd_vld_ff;
   logic [7:0] mean_ff;
   logic [kqs_pkg::SumW-1:0] rem_ff;
   logic [kqs_pkg::SsdW-1:0] ssd_ff;
   logic found_ff, best_single_ff;
   logic [1:0] best_q_ff;
   logic [kqs_pkg::SsdW-1:0] best_ssd_ff;
   logic [kqs_pkg::CntW-1:0] best_den_ff;
   kqs_pkg::rsp_type out_ff;

   logic accept;
   logic [kqs_pkg::CntW-1:0] cur_cnt;
   logic [kqs_pkg::SumW-1:0] cur_sum;
   logic signed [9:0] diff;
   logic [7:0] abs_diff;
   logic [15:0] sq;
   logic [kqs_pkg::CntW-1:0] den_cur;
   logic [kqs_pkg::SumW-1:0] rsum, rq, rr;
   logic [kqs_pkg::CntW-1:0] rn;
   logic [8:0] rq9;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_LOAD);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.data = out_ff;
   assign cur_cnt = cnt_ff[q_ff];
   assign cur_sum = sum_ff[q_ff];
   assign diff = $signed({2'b00, rd_ff}) - $signed({2'b00, mean_ff});
   assign abs_diff = diff[9] ? 8'(-diff) : diff[7:0];
   assign sq = abs_diff * abs_diff;
   assign den_cur = cur_cnt - kqs_pkg::CntW'(1);

   always_comb begin
      rsum = sum_ff[best_q_ff];
      rn = cnt_ff[best_q_ff];
      rq = rem_ff;
      rr = rsum - rq * kqs_pkg::SumW'(rn);
      rq9 = 9'(rq);
      if ((rr << 1) > kqs_pkg::SumW'(rn) ||
          ((rr << 1) == kqs_pkg::SumW'(rn) && rq[0])) begin
         rq9 = rq9 + 9'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: if (accept && req.data.last) state_in = ST_MEAN;
         ST_MEAN: if (cur_cnt < kqs_pkg::CntW'(2) ||
                      kqs_pkg::SumW'({1'b0, mean_ff} + 9'd1) * kqs_pkg::SumW'(cur_cnt)
                      > cur_sum) state_in = ST_WALK;
         ST_WALK: if (cur_cnt < kqs_pkg::CntW'(2) ||
                      (rd_vld_ff && idx_ff == cur_cnt)) state_in = ST_CMP;
         ST_CMP:  state_in = (q_ff == 2'd3) ? ST_ROUND : ST_MEAN;
         ST_ROUND: if (!found_ff ||
                       kqs_pkg::SumW'(rem_ff + kqs_pkg::SumW'(1)) *
                       kqs_pkg::SumW'(cnt_ff[best_q_ff]) > sum_ff[best_q_ff])
                      state_in = ST_OUT;
         ST_OUT:  if (rsp.ready) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && cnt_ff[req.data.quadrant] < kqs_pkg::CntW'(kqs_pkg::QuadCap)) begin
         mem[{req.data.quadrant, kqs_pkg::IdxW'(cnt_ff[req.data.quadrant])}]
            <= req.data.pixel;
      end
      rd_ff <= mem[AddrW'({q_ff, kqs_pkg::IdxW'(idx_ff)})];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         for (int i = 0; i < kqs_pkg::NumQuads; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         ovf_ff <= 1'b0;
         q_ff <= 2'd0;
         idx_ff <= '0;
         rd_vld_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (cnt_ff[req.data.quadrant] < kqs_pkg::CntW'(kqs_pkg::QuadCap)) begin
                     sum_ff[req.data.quadrant] <= sum_ff[req.data.quadrant]
                        + kqs_pkg::SumW'(req.data.pixel);
                     cnt_ff[req.data.quadrant] <= cnt_ff[req.data.quadrant]
                        + kqs_pkg::CntW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
               q_ff <= 2'd0;
               idx_ff <= '0;
               mean_ff <= '0;
               found_ff <= 1'b0;
               best_single_ff <= 1'b0;
            end
            ST_MEAN: begin
               if (state_in == ST_WALK) begin
                  idx_ff <= '0;
                  rd_vld_ff <= 1'b0;
                  ssd_ff <= '0;
               end else begin
                  mean_ff <= mean_ff + 8'd1;
               end
            end
            ST_WALK: begin
               if (rd_vld_ff) begin
                  ssd_ff <= ssd_ff + kqs_pkg::SsdW'(sq);
               end
               rd_vld_ff <= 1'b1;
               if (idx_ff != cur_cnt) idx_ff <= idx_ff + kqs_pkg::CntW'(1);
            end
            ST_CMP: begin
               if (cur_cnt == kqs_pkg::CntW'(1)) begin
                  if (!found_ff) begin
                     found_ff <= 1'b1;
                     best_single_ff <= 1'b1;
                     best_q_ff <= q_ff;
                  end
               end else if (cur_cnt != '0) begin
                  if (!found_ff || best_single_ff ||
                      kqs_pkg::ProdW'(best_ssd_ff) * kqs_pkg::ProdW'(den_cur) >
                      kqs_pkg::ProdW'(ssd_ff) * kqs_pkg::ProdW'(best_den_ff)) begin
                     found_ff <= 1'b1;
                     best_single_ff <= 1'b0;
                     best_q_ff <= q_ff;
                     best_ssd_ff <= ssd_ff;
                     best_den_ff <= den_cur;
                  end
               end
               q_ff <= q_ff + 2'd1;
               idx_ff <= '0;
               mean_ff <= '0;
               rem_ff <= '0;
            end
            ST_ROUND: begin
               if (state_in == ST_OUT) begin
                  if (!found_ff) begin
                     out_ff <= '{8'd0, 2'd0, kqs_pkg::StatusEmpty};
                  end else begin
                     out_ff.mean_value <= (rq9 > 9'd255) ? 8'd255 : rq9[7:0];
                     out_ff.chosen_quadrant <= best_q_ff;
                     out_ff.status <= ovf_ff ? kqs_pkg::StatusOverflow
                                             : kqs_pkg::StatusOk;
                  end
                  for (int i = 0; i < kqs_pkg::NumQuads; i++) begin
                     sum_ff[i] <= '0;
                     cnt_ff[i] <= '0;
                  end
                  ovf_ff <= 1'b0;
               end else begin
                  rem_ff <= rem_ff + kqs_pkg::SumW'(1);
               end
            end
            ST_OUT: ;
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### rtl/kqs_checker.sv
// Port-level checker for the Kuwahara quadrant select unit, bound to the top level.
// Depends on kqs_pkg and the channel interfaces.
`default_nettype none
module kqs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status
);
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == kqs_pkg::StatusOk ||
                     rsp_status == kqs_pkg::StatusOverflow))
      else $error("empty status after a last request");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response after reset");
endmodule

bind kuwahara_quadrant_select_unit kqs_checker u_kqs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.data.status)
);
`default_nettype wire
